### rtl/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// Shared types and constants for the CAN bit timing search block.
// ----------------------------------------------------------------------------
package cbt_pkg;

  localparam int unsigned CLK_W  = 32;
  localparam int unsigned RATE_W = 20;

  localparam logic [CLK_W-1:0] MAIN_CLOCK_RESET = 32'd48000000;

  // search bounds
  localparam logic [3:0] DIV_MAX    = 4'd15;
  localparam logic [5:0] QUANTA_MIN = 6'd1;
  localparam logic [5:0] QUANTA_MAX = 6'd32;
  localparam logic [4:0] SEGS_MIN   = 5'd3;
  localparam logic [4:0] SEGS_MAX   = 5'd17;
  localparam logic [1:0] JUMP_CAP   = 2'd3;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_NO_MATCH  = 2'd1;
  localparam status_t STATUS_ZERO_RATE = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SEARCH,
    ST_DELIVER
  } state_t;

  typedef struct packed {
    logic       done;
    logic       found;
    logic [3:0] d;
    logic [5:0] q;
    logic [4:0] s;
  } search_res_t;

endpackage

### rtl/cbt_divider.sv
// ----------------------------------------------------------------------------
// cbt_divider
// Restoring divider, one quotient bit per cycle: clock rate / bit rate.
// ----------------------------------------------------------------------------
module cbt_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cbt_pkg::CLK_W-1:0]     dividend,
  input  logic [cbt_pkg::RATE_W-1:0]    divisor,
  output logic [cbt_pkg::CLK_W-1:0]     quotient,
  output logic                          done
);

  logic                          busy;
  logic [4:0]                    count;
  logic [cbt_pkg::RATE_W-1:0]    dvsr;
  logic [cbt_pkg::RATE_W-1:0]    rem;
  logic [cbt_pkg::RATE_W:0]      rem_sh;
  logic [cbt_pkg::RATE_W:0]      rem_sub;
  logic                          fits;

  assign rem_sh  = {rem, quotient[cbt_pkg::CLK_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvsr};
  assign fits    = (rem_sh >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        count    <= '0;
        dvsr     <= divisor;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        // remainder stays below the divisor, so the top bit drops out
        rem      <= fits ? rem_sub[cbt_pkg::RATE_W-1:0] : rem_sh[cbt_pkg::RATE_W-1:0];
        quotient <= {quotient[cbt_pkg::CLK_W-2:0], fits};
        count    <= count + 5'd1;
        if (count == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

### rtl/cbt_search.sv
// ----------------------------------------------------------------------------
// cbt_search
// Sequencer over prescaler, quanta and segments with one shared multiplier
// and comparator; one candidate triple per cycle.
// ----------------------------------------------------------------------------
module cbt_search (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [cbt_pkg::CLK_W-1:0]  cpb,
  output cbt_pkg::search_res_t       res
);

  logic       running;
  logic       done;
  logic       found;
  logic [3:0] d;
  logic [5:0] q;
  logic [4:0] s;
  logic [9:0] qd;      // q * (d + 1)
  logic [14:0] prod;
  logic       hit;

  assign prod = 15'(s) * 15'(qd);
  assign hit  = ({17'd0, prod} == cpb);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      found   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        found   <= 1'b0;
        d  <= '0;
        q  <= cbt_pkg::QUANTA_MIN;
        s  <= cbt_pkg::SEGS_MIN;
        qd <= 10'd1;
      end else if (running) begin
        if (hit) begin
          running <= 1'b0;
          found   <= 1'b1;
          done    <= 1'b1;
        end else if (s != cbt_pkg::SEGS_MAX) begin
          s <= s + 5'd1;
        end else begin
          s <= cbt_pkg::SEGS_MIN;
          if (q != cbt_pkg::QUANTA_MAX) begin
            q  <= q + 6'd1;
            qd <= qd + {6'd0, d} + 10'd1;
          end else if (d != cbt_pkg::DIV_MAX) begin
            q  <= cbt_pkg::QUANTA_MIN;
            d  <= d + 4'd1;
            qd <= {6'd0, d} + 10'd2;
          end else begin
            running <= 1'b0;
            done    <= 1'b1;
          end
        end
      end
    end
  end

  assign res = {done, found, d, q, s};

endmodule

### rtl/can_bit_timing_search.sv
// ----------------------------------------------------------------------------
// can_bit_timing_search
// CAN bit timing search: clock rate / bit rate, then first matching
// prescaler, quanta and segment split.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_data write main_clock_hz; cfg_ready is always
//   high and writes are expected only while the block is idle.
//   req_valid/req_stall carries bit_rate; a transaction is taken at an edge
//   with req_valid high and req_stall low. req_stall is high from the
//   accepted transaction until its result has been moved into the output
//   register.
//   res_valid/res_stall carries clock_divider, timing_word and status. The
//   output register holds the result while res_stall is high; the next
//   request may be accepted meanwhile, but its result waits in the
//   sequencer until the register is free.
//   Path: a zero bit rate goes straight to the output load. Otherwise the
//   bit-serial divider runs first, then the sequencer is started and tests
//   one candidate per cycle in the shared multiply-compare unit (up to
//   16*32*15 = 7680 candidates), and then the result is loaded into the
//   output register. The next request is taken only once the load has
//   returned the sequencer to idle, so requests do not overlap.
//   Reset: main_clock_hz returns to 48000000, sequencer idle, output empty.
// ----------------------------------------------------------------------------
module can_bit_timing_search (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [cbt_pkg::CLK_W-1:0]  cfg_data,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [cbt_pkg::RATE_W-1:0] bit_rate,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [3:0]                 clock_divider,
  output logic [14:0]                timing_word,
  output cbt_pkg::status_t           status
);

  cbt_pkg::state_t      state, state_next;
  cbt_pkg::status_t     result_status;
  cbt_pkg::search_res_t srch;
  logic [cbt_pkg::CLK_W-1:0] main_clock_hz;
  logic [cbt_pkg::CLK_W-1:0] cpb;
  logic accept, div_start, div_done, srch_start, load_res, slot_free;
  logic [3:0]  rest;
  logic [2:0]  ph1, ph2;
  logic [1:0]  jump;
  logic [14:0] word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_clock_hz <= cbt_pkg::MAIN_CLOCK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      main_clock_hz <= cfg_data;
    end
  end

  cbt_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (main_clock_hz),
    .divisor  (bit_rate),
    .quotient (cpb),
    .done     (div_done)
  );

  cbt_search u_srch (
    .clk   (clk),
    .rst   (rst),
    .start (srch_start),
    .cpb   (cpb),
    .res   (srch)
  );

  assign accept    = req_valid && !req_stall;
  assign slot_free = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    case (state)
      cbt_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = (bit_rate == '0) ? cbt_pkg::ST_DELIVER : cbt_pkg::ST_DIVIDE;
        end
      end
      cbt_pkg::ST_DIVIDE: begin
        if (div_done) state_next = cbt_pkg::ST_SEARCH;
      end
      cbt_pkg::ST_SEARCH: begin
        if (srch.done) state_next = cbt_pkg::ST_DELIVER;
      end
      cbt_pkg::ST_DELIVER: begin
        if (slot_free) state_next = cbt_pkg::ST_IDLE;
      end
      default: state_next = cbt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall  = 1'b1;
    div_start  = 1'b0;
    srch_start = 1'b0;
    load_res   = 1'b0;
    case (state)
      cbt_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        div_start = req_valid && (bit_rate != '0);
      end
      cbt_pkg::ST_DIVIDE:  srch_start = div_done;
      cbt_pkg::ST_SEARCH:  ;
      cbt_pkg::ST_DELIVER: load_res = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_status <= cbt_pkg::STATUS_ZERO_RATE;
    end else if (state == cbt_pkg::ST_SEARCH && srch.done) begin
      result_status <= srch.found ? cbt_pkg::STATUS_OK : cbt_pkg::STATUS_NO_MATCH;
    end
  end

  // segments less three: smaller half to phase 1, rest to phase 2
  assign rest = 4'(srch.s - cbt_pkg::SEGS_MIN);
  assign ph1  = rest[3:1];
  assign ph2  = 3'(rest - {1'b0, ph1});
  assign jump = (ph1 > {1'b0, cbt_pkg::JUMP_CAP}) ? cbt_pkg::JUMP_CAP : ph1[1:0];
  assign word = {ph2, 1'b0, ph1, jump, 6'(srch.q - cbt_pkg::QUANTA_MIN)};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_res) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      status <= result_status;
      if (result_status == cbt_pkg::STATUS_OK) begin
        clock_divider <= srch.d;
        timing_word   <= word;
      end else begin
        clock_divider <= '0;
        timing_word   <= '0;
      end
    end
  end

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && status != cbt_pkg::STATUS_OK) |-> (clock_divider == '0 && timing_word == '0))
    else $error("failed result carries nonzero timing");

  a_search_exit: assert property (@(posedge clk) disable iff (rst)
    (state == cbt_pkg::ST_SEARCH) |=>
      (state == cbt_pkg::ST_SEARCH || state == cbt_pkg::ST_DELIVER))
    else $error("search state left on a bad path");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == cbt_pkg::ST_DIVIDE))
    else $error("divider finished outside divide state");

  a_load_frees_seq: assert property (@(posedge clk) disable iff (rst)
    load_res |=> (res_valid && state == cbt_pkg::ST_IDLE))
    else $error("result load did not release the sequencer");

endmodule

### tb/can_bit_timing_search_tb.sv
// ----------------------------------------------------------------------------
// can_bit_timing_search_tb
// Self-checking bench for the CAN bit timing search. Bit rates are queued by
// the stimulus process and driven by a clocked driver. Each accepted rate is
// run through an independent search against the current clock rate, and the
// monitor checks every result, in order, against that prediction. Both
// channels idle at random until the last stretch; one long receiver hold-off.
// ----------------------------------------------------------------------------
module can_bit_timing_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_HALF       = 5;
  localparam int unsigned WATCHDOG_LIMIT = 100000;
  localparam int unsigned LONG_HOLD      = 20000;
  localparam int unsigned REPORT_MAX     = 10;

  typedef struct packed {
    logic [cbt_pkg::RATE_W-1:0] rate;
    logic [3:0]                 clock_divider;
    logic [14:0]                timing_word;
    cbt_pkg::status_t           status;
  } bit_timing_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [cbt_pkg::CLK_W-1:0]  cfg_data  = '0;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  logic [cbt_pkg::RATE_W-1:0] bit_rate  = '0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  logic [3:0]                 clock_divider;
  logic [14:0]                timing_word;
  cbt_pkg::status_t           status;

  logic [cbt_pkg::RATE_W-1:0] rate_queue[$];
  bit_timing_t                expected_timing[$];
  bit_timing_t                oldest_timing;
  logic [cbt_pkg::CLK_W-1:0]  clock_hz_model   = cbt_pkg::MAIN_CLOCK_RESET;
  bit                         idle_on          = 1'b0;
  int unsigned                long_hold_asks   = 0;
  int unsigned                long_hold_served = 0;
  int unsigned                req_gap          = 0;
  int unsigned                res_hold         = 0;
  int unsigned                quiet_cycles     = 0;
  int unsigned                mismatch_count   = 0;

  can_bit_timing_search i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .bit_rate      (bit_rate),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .clock_divider (clock_divider),
    .timing_word   (timing_word),
    .status        (status)
  );

  always #CLK_HALF clk = ~clk;

  // first (prescaler, quanta, segments) triple, ascending and nested in that
  // order, whose product equals clocks per bit
  function automatic bit_timing_t predict_bit_timing(
    input logic [cbt_pkg::RATE_W-1:0] rate,
    input logic [cbt_pkg::CLK_W-1:0]  clock_hz
  );
    bit_timing_t               res;
    logic [cbt_pkg::CLK_W-1:0] clocks_per_bit;
    logic [5:0]                quanta_m1;
    logic [3:0]                phase1;
    logic [2:0]                phase2;
    logic [1:0]                jump;
    int unsigned               rest;
    bit                        hit;
    res.rate          = rate;
    res.clock_divider = '0;
    res.timing_word   = '0;
    res.status        = cbt_pkg::STATUS_NO_MATCH;
    hit               = 1'b0;
    if (rate == '0) begin
      res.status = cbt_pkg::STATUS_ZERO_RATE;
      return res;
    end
    clocks_per_bit = clock_hz / rate;
    for (int unsigned d = 0; d <= cbt_pkg::DIV_MAX && !hit; d++) begin
      for (int unsigned q = cbt_pkg::QUANTA_MIN; q <= cbt_pkg::QUANTA_MAX && !hit; q++) begin
        for (int unsigned s = cbt_pkg::SEGS_MIN; s <= cbt_pkg::SEGS_MAX && !hit; s++) begin
          if (clocks_per_bit == s * q * (d + 1)) begin
            hit       = 1'b1;
            rest      = s - cbt_pkg::SEGS_MIN;
            quanta_m1 = 6'(q - 1);
            phase1    = 4'(rest / 2);
            phase2    = 3'(rest - rest / 2);
            jump      = (phase1 > cbt_pkg::JUMP_CAP) ? cbt_pkg::JUMP_CAP : phase1[1:0];
            res.clock_divider = 4'(d);
            res.timing_word   = {phase2, phase1, jump, quanta_m1};
            res.status        = cbt_pkg::STATUS_OK;
          end
        end
      end
    end
    return res;
  endfunction

  // mostly rates that land on a valid triple at the current clock; noisy
  // picks add zero rates and arbitrary rates, which rarely match
  function automatic logic [cbt_pkg::RATE_W-1:0] pick_rate(input bit noisy);
    int unsigned               d;
    int unsigned               q;
    int unsigned               s;
    logic [cbt_pkg::CLK_W-1:0] r;
    if (noisy) begin
      case ($urandom_range(0, 9))
        0:       return '0;
        1, 2:    begin
          r = $urandom();
          return r[cbt_pkg::RATE_W-1:0];
        end
        default: ;
      endcase
    end
    for (int attempt = 0; attempt < 8; attempt++) begin
      d = (attempt < 4) ? $urandom_range(0, 3) : $urandom_range(0, cbt_pkg::DIV_MAX);
      q = $urandom_range(cbt_pkg::QUANTA_MIN, cbt_pkg::QUANTA_MAX);
      s = $urandom_range(cbt_pkg::SEGS_MIN, cbt_pkg::SEGS_MAX);
      r = clock_hz_model / (s * q * (d + 1));
      if (r != '0 && r <= {cbt_pkg::RATE_W{1'b1}})
        return r[cbt_pkg::RATE_W-1:0];
    end
    r = $urandom();
    return r[cbt_pkg::RATE_W-1:0];
  endfunction

  task automatic offer(input logic [cbt_pkg::RATE_W-1:0] rate);
    rate_queue.push_back(rate);
  endtask

  task automatic offer_random(input int unsigned count, input bit noisy);
    repeat (count) rate_queue.push_back(pick_rate(noisy));
  endtask

  // sender holds back until every transaction has come out the far side
  task automatic settle();
    do @(negedge clk);
    while (rate_queue.size() != 0 || req_valid || expected_timing.size() != 0);
  endtask

  task automatic write_main_clock(input logic [cbt_pkg::CLK_W-1:0] hz);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= hz;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    clock_hz_model = hz;
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      req_gap   <= 0;
    end else begin
      if (req_valid && !req_stall)
        expected_timing.push_back(predict_bit_timing(bit_rate, clock_hz_model));
      if (!req_valid || !req_stall) begin
        if (req_gap != 0) begin
          req_gap   <= req_gap - 1;
          req_valid <= 1'b0;
        end else if (rate_queue.size() != 0) begin
          req_valid <= 1'b1;
          bit_rate  <= rate_queue.pop_front();
          if (idle_on && $urandom_range(0, 5) == 0)
            req_gap <= $urandom_range(1, 9);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      res_stall        <= 1'b0;
      res_hold         <= 0;
      long_hold_served <= 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_timing.size() == 0) begin
          if (mismatch_count < REPORT_MAX)
            $display("unexpected result: divider %0d word %h status %0d",
                     clock_divider, timing_word, status);
          mismatch_count++;
        end else begin
          oldest_timing = expected_timing.pop_front();
          if (clock_divider !== oldest_timing.clock_divider ||
              timing_word !== oldest_timing.timing_word ||
              status !== oldest_timing.status) begin
            if (mismatch_count < REPORT_MAX)
              $display("rate %0d: expected divider %0d word %h status %0d, got %0d %h %0d",
                       oldest_timing.rate, oldest_timing.clock_divider,
                       oldest_timing.timing_word, oldest_timing.status,
                       clock_divider, timing_word, status);
            mismatch_count++;
          end
        end
      end
      if (res_hold != 0) begin
        res_hold  <= res_hold - 1;
        res_stall <= 1'b1;
      end else if (long_hold_served != long_hold_asks) begin
        long_hold_served <= long_hold_served + 1;
        res_hold         <= LONG_HOLD - 1;
        res_stall        <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_hold  <= $urandom_range(0, 8);
        res_stall <= 1'b1;
      end else begin
        res_stall <= 1'b0;
      end
    end
  end

  // watchdog: no transaction on any channel for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // clock rate left at its reset value: zero rate, field extremes, no match
    @(negedge clk);
    idle_on = 1'b1;
    offer('0);
    offer(20'hFFFFF);
    offer(20'd1);
    offer(20'hAAAAA);
    offer(20'h55555);
    offer(20'd1000000);
    offer(20'd500000);
    offer(20'd250000);
    offer(20'd5514);
    settle();

    // quick matches first so the block backs up behind the long hold-off
    long_hold_asks++;
    offer_random(6, 1'b0);
    offer_random(34, 1'b1);
    settle();

    // largest prescaler, widest segments and capped jump width
    write_main_clock(32'd8704000);
    offer(20'd1000);
    offer(20'd512000);
    offer(20'd1000000);
    offer(20'd16000);
    settle();

    // shortest segment total
    write_main_clock(32'd3000000);
    offer(20'd1000000);
    offer(20'd176470);
    settle();

    // zero clock rate never matches
    write_main_clock('0);
    offer(20'd1);
    offer(20'hFFFFF);
    settle();

    write_main_clock(32'd1);
    offer(20'd1);
    offer(20'd2);
    settle();

    write_main_clock('1);
    offer(20'hFFFFF);
    offer_random(10, 1'b1);
    settle();

    write_main_clock($urandom_range(1000000, 100000000));
    offer_random(20, 1'b1);
    settle();

    // closing stretch without idling on either side
    idle_on = 1'b0;
    offer_random(20, 1'b1);
    settle();

    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && expected_timing.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
